[rtl/core/rlsd_pkg.sv]
// ----------------------------------------------------------------------------
// rlsd_pkg
// shared types, codes and defaults for the ring sample store and readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlsd_pkg;

   // default sizes
   localparam int DEF_RING_DEPTH   = 64;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // field widths
   localparam int VALUE_W   = 16;
   localparam int DEST_W    = 6;
   localparam int COUNT_W   = 7;
   localparam int CFG_LEN_W = 7;
   localparam int CFG_CH_W  = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   // register reset values
   localparam logic [CFG_LEN_W-1:0] LEN_RESET = 7'd64;
   localparam logic [CFG_CH_W-1:0]  CH_RESET  = 5'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;

   // action codes
   localparam logic ACT_STORE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef struct packed {
      logic               action;
      logic [VALUE_W-1:0] sample;
      logic [COUNT_W-1:0] count;
      logic               deinterleave;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [DEST_W-1:0]  dest_index;
      logic               last;
      logic               error;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_STREAM,
      ST_ERROR
   } state_type;

endpackage

`default_nettype wire

[rtl/core/rlsd_ring.sv]
// ----------------------------------------------------------------------------
// rlsd_ring
// sample memory, one write and one registered read port, per-entry valid bits
// so that entries never written since reset read as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlsd_ring #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] data_ff;
   logic              data_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            data_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = data_vld_ff ? data_ff : '0;

endmodule

`default_nettype wire

[rtl/core/rlsd_div.sv]
// ----------------------------------------------------------------------------
// rlsd_div
// restoring divider, one quotient bit per cycle, for the deinterleave stride
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlsd_div #(
   parameter int N_W = 7,
   parameter int D_W = 5
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] dividend,
   input  wire logic [D_W-1:0] divisor,
   output      logic           busy,
   output      logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   dvs_ff, dvs_in;
   logic [D_W:0]     trial;
   logic             take;

   always_comb begin
      trial  = {rem_ff, quo_ff[N_W-1]};
      take   = trial >= {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(N_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = take ? D_W'(trial - {1'b0, dvs_ff}) : trial[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/core/ring_last_samples_deinterleaver.sv]
// ----------------------------------------------------------------------------
// ring_last_samples_deinterleaver
// store word: taken while idle, one per cycle back to back, no result
// readout word: after accept the stride divider runs, then the fetch state reads
// memory and the first result follows, then one per cycle while rsp_ready is high
// error result in the cycle after accept; next request taken after the last result
// reset: sync, sets registers to defaults, clears position and memory valid bits (reads as zero)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_last_samples_deinterleaver #(
   parameter int RING_DEPTH   = rlsd_pkg::DEF_RING_DEPTH,
   parameter int SAMPLE_WIDTH = rlsd_pkg::DEF_SAMPLE_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire rlsd_pkg::req_word_type            req_word,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      rlsd_pkg::rsp_word_type            rsp_word,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [rlsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rlsd_pkg::CSR_DAT_W-1:0]    csr_data
);

   import rlsd_pkg::*;

   localparam int AW    = $clog2(RING_DEPTH);
   localparam int LEN_W = $clog2(RING_DEPTH + 1);

   state_type              state_ff, state_in;
   logic [CFG_LEN_W-1:0]   len_cfg_ff;
   logic [CFG_CH_W-1:0]    ch_cfg_ff;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   sort_ff, sort_in;
   logic [AW-1:0]          src_ff, src_in;
   logic [COUNT_W-1:0]     idx_ff, idx_in;
   logic [CFG_CH_W-1:0]    chan_ff, chan_in;
   logic [DEST_W-1:0]      frame_ff, frame_in;
   logic [DEST_W-1:0]      dest_ff, dest_in;

   logic [LEN_W-1:0]       len_eff;
   logic [CFG_CH_W-1:0]    chans;
   logic [AW-1:0]          pos_eff;
   logic [LEN_W-1:0]       pos_inc;
   logic [AW-1:0]          pos_wrap;
   logic                   count_bad;
   logic [LEN_W:0]         src_sum;
   logic [AW-1:0]          src_start;
   logic [LEN_W-1:0]       src_inc;
   logic [AW-1:0]          src_next;
   logic                   is_last;
   logic [DEST_W-1:0]      frame_inc;

   logic                   wr_en;
   logic                   rd_en;
   logic [SAMPLE_WIDTH-1:0] rd_data;
   logic                   div_start;
   logic                   div_busy;
   logic [COUNT_W-1:0]     stride;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= LEN_RESET;
         ch_cfg_ff  <= CH_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_BUFFER_LENGTH) begin
            len_cfg_ff <= csr_data[CFG_LEN_W-1:0];
         end else if (csr_index == CSR_CHANNEL_COUNT) begin
            ch_cfg_ff <= csr_data[CFG_CH_W-1:0];
         end
      end
   end

   // address arithmetic
   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_cfg_ff > CFG_LEN_W'(RING_DEPTH)) begin
         len_eff = LEN_W'(RING_DEPTH);
      end else begin
         len_eff = len_cfg_ff[LEN_W-1:0];
      end
      chans     = (ch_cfg_ff == '0) ? CFG_CH_W'(1) : ch_cfg_ff;
      pos_eff   = (LEN_W'(pos_ff) >= len_eff) ? '0 : pos_ff;
      pos_inc   = LEN_W'(pos_eff) + LEN_W'(1);
      pos_wrap  = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
      count_bad = (req_word.count == '0) || (req_word.count > COUNT_W'(len_eff));
      src_sum   = (LEN_W+1)'(pos_eff) + (LEN_W+1)'(len_eff)
                  - (LEN_W+1)'(req_word.count);
      src_start = (src_sum >= (LEN_W+1)'(len_eff))
                  ? AW'(src_sum - (LEN_W+1)'(len_eff)) : src_sum[AW-1:0];
      src_inc   = LEN_W'(src_ff) + LEN_W'(1);
      src_next  = (src_inc == len_eff) ? '0 : src_inc[AW-1:0];
      is_last   = (idx_ff + COUNT_W'(1)) == count_ff;
      frame_inc = frame_ff + DEST_W'(1);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      sort_in   = sort_ff;
      src_in    = src_ff;
      idx_in    = idx_ff;
      chan_in   = chan_ff;
      frame_in  = frame_ff;
      dest_in   = dest_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_word.action == ACT_STORE) begin
                  wr_en  = 1'b1;
                  pos_in = pos_wrap;
               end else if (count_bad) begin
                  state_in = ST_ERROR;
               end else begin
                  div_start = 1'b1;
                  count_in  = req_word.count;
                  sort_in   = req_word.deinterleave;
                  src_in    = src_start;
                  idx_in    = '0;
                  chan_in   = '0;
                  frame_in  = '0;
                  dest_in   = '0;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            src_in   = src_next;
            state_in = ST_STREAM;
         end
         ST_STREAM: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en  = 1'b1;
                  src_in = src_next;
                  idx_in = idx_ff + COUNT_W'(1);
                  if (chan_ff + CFG_CH_W'(1) == chans) begin
                     chan_in  = '0;
                     frame_in = frame_inc;
                     dest_in  = frame_inc;
                  end else begin
                     chan_in = chan_ff + CFG_CH_W'(1);
                     dest_in = dest_ff + stride[DEST_W-1:0];
                  end
               end
            end
         end
         ST_ERROR: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      sort_ff  <= sort_in;
      src_ff   <= src_in;
      idx_ff   <= idx_in;
      chan_ff  <= chan_in;
      frame_ff <= frame_in;
      dest_ff  <= dest_in;
   end

   // result word
   always_comb begin
      if (state_ff == ST_ERROR) begin
         rsp_word.value      = '0;
         rsp_word.dest_index = '0;
         rsp_word.last       = 1'b1;
         rsp_word.error      = 1'b1;
      end else begin
         rsp_word.value      = VALUE_W'(rd_data);
         rsp_word.dest_index = sort_ff ? dest_ff : idx_ff[DEST_W-1:0];
         rsp_word.last       = is_last;
         rsp_word.error      = 1'b0;
      end
   end

   rlsd_ring #(
      .DEPTH  (RING_DEPTH),
      .DATA_W (SAMPLE_WIDTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (pos_eff),
      .wr_data (req_word.sample[SAMPLE_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   rlsd_div #(
      .N_W (COUNT_W),
      .D_W (CFG_CH_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_word.count),
      .divisor  (chans),
      .busy     (div_busy),
      .quotient (stride)
   );

   // checks
   a_div_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside divide phase");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM |-> idx_ff < count_ff)
      else $error("readout index beyond count");

   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM |-> LEN_W'(src_ff) < len_eff)
      else $error("read address beyond ring length");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_word.last |=> req_ready)
      else $error("request not taken after last result");

endmodule

`default_nettype wire
